[rtl/btob_pkg.sv]
// Shared types and constants of the bilinear texel over-blend pipeline.
package btob_pkg;

    localparam int WEIGHT_BITS_DEF = 8;
    localparam int CHAN_BITS       = 8;
    localparam int NUM_CHAN        = 4;
    localparam int WEIGHT_FIELD_W  = 9;
    localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'hFF;

    typedef struct packed {
        logic [31:0]               texel_top_left;
        logic [31:0]               texel_top_right;
        logic [31:0]               texel_bottom_left;
        logic [31:0]               texel_bottom_right;
        logic [WEIGHT_FIELD_W-1:0] weight_x;
        logic [WEIGHT_FIELD_W-1:0] weight_y;
        logic [31:0]               dest_pixel;
        logic                      inside_req;
    } t_btob_in;

    typedef struct packed {
        logic [31:0] out_pixel;
        logic        write_enable;
    } t_btob_out;

    // Filtered texel with the fields that ride alongside it to the blend stages.
    typedef struct packed {
        logic [31:0] filt;
        logic [31:0] dest_pixel;
        logic        inside_req;
    } t_btob_mid;

endpackage

[rtl/btob_filter.sv]
// Three-stage bilinear filter: weight clamp, horizontal lerps, vertical lerp.
module btob_filter #(
    parameter int WEIGHT_BITS = btob_pkg::WEIGHT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  btob_pkg::t_btob_in i_data,
    output logic               o_vld,
    output btob_pkg::t_btob_mid o_data
);
    import btob_pkg::*;

    localparam int WW = WEIGHT_BITS + 1;
    localparam int SW = WEIGHT_BITS + CHAN_BITS + 1;
    localparam logic [WW-1:0] ONE = {1'b1, {WEIGHT_BITS{1'b0}}};

    logic [2:0] r_vld;

    // Stage 1: registered texels and clamped weights.
    logic [NUM_CHAN-1:0][CHAN_BITS-1:0] r_tl, r_tr, r_bl, r_br;
    logic [WW-1:0]                      r_wx, r_wy;
    logic [31:0]                        r_dest1;
    logic                               r_in1;
    logic [WW-1:0]                      n_wx, n_wy;
    logic [WW+WEIGHT_FIELD_W-1:0]       ext_wx, ext_wy;

    // Stage 2: top and bottom row results.
    logic [NUM_CHAN-1:0][CHAN_BITS-1:0] r_top, r_bot, n_top, n_bot;
    logic [WW-1:0]                      r_wy2;
    logic [31:0]                        r_dest2;
    logic                               r_in2;

    // Stage 3: filtered texel.
    logic [NUM_CHAN-1:0][CHAN_BITS-1:0] r_filt, n_filt;
    logic [31:0]                        r_dest3;
    logic                               r_in3;

    always_comb begin
        ext_wx = {{WW{1'b0}}, i_data.weight_x};
        ext_wy = {{WW{1'b0}}, i_data.weight_y};
        n_wx   = (ext_wx[WW-1:0] > ONE) ? ONE : ext_wx[WW-1:0];
        n_wy   = (ext_wy[WW-1:0] > ONE) ? ONE : ext_wy[WW-1:0];
    end

    always_comb begin
        for (int k = 0; k < NUM_CHAN; k++) begin
            n_top[k] = CHAN_BITS'((SW'(r_tl[k]) * SW'(ONE - r_wx)
                                 + SW'(r_tr[k]) * SW'(r_wx)) >> WEIGHT_BITS);
            n_bot[k] = CHAN_BITS'((SW'(r_bl[k]) * SW'(ONE - r_wx)
                                 + SW'(r_br[k]) * SW'(r_wx)) >> WEIGHT_BITS);
            n_filt[k] = CHAN_BITS'((SW'(r_top[k]) * SW'(ONE - r_wy2)
                                  + SW'(r_bot[k]) * SW'(r_wy2)) >> WEIGHT_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tl    <= i_data.texel_top_left;
        r_tr    <= i_data.texel_top_right;
        r_bl    <= i_data.texel_bottom_left;
        r_br    <= i_data.texel_bottom_right;
        r_wx    <= n_wx;
        r_wy    <= n_wy;
        r_dest1 <= i_data.dest_pixel;
        r_in1   <= i_data.inside_req;

        r_top   <= n_top;
        r_bot   <= n_bot;
        r_wy2   <= r_wy;
        r_dest2 <= r_dest1;
        r_in2   <= r_in1;

        r_filt  <= n_filt;
        r_dest3 <= r_dest2;
        r_in3   <= r_in2;
    end

    assign o_vld             = r_vld[2];
    assign o_data.filt       = r_filt;
    assign o_data.dest_pixel = r_dest3;
    assign o_data.inside_req = r_in3;

    a_vld_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> $past(i_vld, 3))
        else $error("filter word out without matching word in");

    a_wx_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_wx <= ONE && r_wy <= ONE))
        else $error("weight not clamped to one");

    a_wy_carried: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> r_wy2 == $past(r_wy))
        else $error("vertical weight lost between stages");

endmodule

[rtl/bilinear_texel_over_blend_top.sv]
// Top level of the bilinear texel filter with premultiplied-alpha over blend.
//
//  channel   direction  handshake            payload
//  command   in         i_start / o_busy     i_data  (t_btob_in)
//  result    out        o_valid strobe       o_data  (t_btob_out)
//
// A word is taken at every edge where i_start is high; o_busy is never raised.
// Each word appears on o_data with o_valid for one cycle.
// The path runs through the pipeline: clamp, x lerp, y lerp, blend multiply,
// divide-by-255 and saturate, one register stage each.
// Reset clears only the valid bits; the receiver cannot stall the pipeline.
module bilinear_texel_over_blend_top #(
    parameter int WEIGHT_BITS = btob_pkg::WEIGHT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  btob_pkg::t_btob_in  i_data,
    output logic                o_busy,
    output logic                o_valid,
    output btob_pkg::t_btob_out o_data
);
    import btob_pkg::*;

    localparam int PW = 2 * CHAN_BITS;

    logic      filt_vld;
    t_btob_mid filt_data;

    btob_filter #(
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start),
        .i_data  (i_data),
        .o_vld   (filt_vld),
        .o_data  (filt_data)
    );

    logic [1:0] r_vld;

    // Stage 4: destination channel times the uncovered fraction.
    logic [2:0][PW-1:0]        r_prod, n_prod;
    logic [2:0][CHAN_BITS-1:0] r_col;
    logic                      r_in4;

    // Stage 5: result word.
    logic [2:0][CHAN_BITS-1:0] n_chan;
    logic [PW:0]               quo;
    logic [CHAN_BITS:0]        sum;
    t_btob_out                 r_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_prod[k] = PW'(filt_data.dest_pixel[k*CHAN_BITS +: CHAN_BITS])
                      * PW'(CHAN_MAX - filt_data.filt[3*CHAN_BITS +: CHAN_BITS]);
        end
    end

    // x / 255 equals (x + (x >> 8) + 1) >> 8 over the whole product range.
    always_comb begin
        quo = '0;
        sum = '0;
        for (int k = 0; k < 3; k++) begin
            quo = ((PW+1)'(r_prod[k]) + (PW+1)'(r_prod[k] >> CHAN_BITS) + (PW+1)'(1))
                  >> CHAN_BITS;
            sum = (CHAN_BITS+1)'(r_col[k]) + quo[CHAN_BITS:0];
            n_chan[k] = sum[CHAN_BITS] ? CHAN_MAX : sum[CHAN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], filt_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_col  <= filt_data.filt[3*CHAN_BITS-1:0];
        r_in4  <= filt_data.inside_req;

        r_out.out_pixel    <= {CHAN_MAX, n_chan[2], n_chan[1], n_chan[0]};
        r_out.write_enable <= r_in4;
    end

    assign o_busy  = 1'b0;
    assign o_valid = r_vld[1];
    assign o_data  = r_out;

    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 5))
        else $error("result word without a matching command word");

    a_alpha_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.out_pixel[31:24] == CHAN_MAX)
        else $error("output alpha not opaque");

    a_we_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.write_enable == $past(i_data.inside_req, 5))
        else $error("write enable does not follow the inside flag");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised on a fully pipelined path");

endmodule

[verif/tb_bilinear_texel_over_blend_top.sv]
// Self-checking testbench for the bilinear texel filter with premultiplied-alpha over blend.
module tb_bilinear_texel_over_blend_top;
    import btob_pkg::*;

    localparam int WGT_BITS   = WEIGHT_BITS_DEF;
    localparam int WGT_ONE    = 1 << WGT_BITS;
    localparam int WGT_MASK   = (2 << WGT_BITS) - 1;
    localparam int PIPE_DEPTH = 5;
    localparam int IDLE_LIMIT = 2000;
    localparam int RAND_WORDS = 1700;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_start = 1'b0;
    t_btob_in  i_data  = '0;
    logic      o_busy;
    logic      o_valid;
    t_btob_out o_data;

    t_btob_in  texel_words_q[$];
    t_btob_out blended_px_q[$];

    int gap_left       = 0;
    int burst_left     = 0;
    int words_taken    = 0;
    int words_planned  = 0;
    int results_seen   = 0;
    int errors         = 0;
    int idle_cycles    = 0;
    int heavy_weights  = 0;
    int outside_words  = 0;
    int clipped_chans  = 0;

    bilinear_texel_over_blend_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_data  (i_data),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Only the low WGT_BITS+1 bits count, and anything above one clamps to one.
    function automatic int unsigned clamp_weight(logic [WEIGHT_FIELD_W-1:0] raw);
        int unsigned w;
        w = int'(raw) & WGT_MASK;
        return (w > WGT_ONE) ? WGT_ONE : w;
    endfunction

    function automatic int unsigned lerp_chan(int unsigned a, int unsigned b, int unsigned w);
        return (a * (WGT_ONE - w) + b * w) >> WGT_BITS;
    endfunction

    function automatic t_btob_out filter_and_blend(t_btob_in word);
        int unsigned wx;
        int unsigned wy;
        int unsigned top;
        int unsigned bot;
        int unsigned filt[NUM_CHAN];
        int unsigned dch;
        int unsigned v;
        t_btob_out   px;
        wx = clamp_weight(word.weight_x);
        wy = clamp_weight(word.weight_y);
        for (int k = 0; k < NUM_CHAN; k++) begin
            top = lerp_chan(32'(word.texel_top_left[8*k +: 8]),
                            32'(word.texel_top_right[8*k +: 8]), wx);
            bot = lerp_chan(32'(word.texel_bottom_left[8*k +: 8]),
                            32'(word.texel_bottom_right[8*k +: 8]), wx);
            filt[k] = lerp_chan(top, bot, wy);
        end
        px.out_pixel = '0;
        px.out_pixel[31:24] = CHAN_MAX;
        for (int k = 0; k < 3; k++) begin
            dch = 32'(word.dest_pixel[8*k +: 8]);
            v = filt[k] + (dch * (CHAN_MAX - filt[3])) / CHAN_MAX;
            if (v > CHAN_MAX) begin
                v = CHAN_MAX;
                clipped_chans++;
            end
            px.out_pixel[8*k +: 8] = v[7:0];
        end
        px.write_enable = word.inside_req;
        return px;
    endfunction

    // Texels are half arbitrary, partly well-formed premultiplied colour, partly extremes.
    function automatic logic [31:0] rand_texel();
        logic [31:0] t;
        int unsigned mode;
        t = $urandom();
        mode = $urandom_range(0, 9);
        if (mode < 3) begin
            for (int k = 0; k < 3; k++) begin
                t[8*k +: 8] = 8'($urandom_range(0, int'(t[31:24])));
            end
        end else if (mode < 5) begin
            for (int k = 0; k < NUM_CHAN; k++) begin
                case ($urandom_range(0, 2))
                    0: t[8*k +: 8] = 8'h00;
                    1: t[8*k +: 8] = 8'hFF;
                    default: ;
                endcase
            end
        end
        return t;
    endfunction

    function automatic logic [WEIGHT_FIELD_W-1:0] rand_weight();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return WEIGHT_FIELD_W'(WGT_ONE);
        if (r < 26) return WEIGHT_FIELD_W'($urandom_range(WGT_ONE + 1, 511));
        return WEIGHT_FIELD_W'($urandom_range(0, WGT_ONE));
    endfunction

    // Mostly back to back or short pauses, now and then a long one or a burst with none.
    function automatic int pick_gap();
        int unsigned r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    task automatic queue_word(logic [31:0] tl, logic [31:0] tr, logic [31:0] bl,
                              logic [31:0] br, logic [WEIGHT_FIELD_W-1:0] wx,
                              logic [WEIGHT_FIELD_W-1:0] wy, logic [31:0] dst,
                              logic in_sprite);
        t_btob_in word;
        word.texel_top_left     = tl;
        word.texel_top_right    = tr;
        word.texel_bottom_left  = bl;
        word.texel_bottom_right = br;
        word.weight_x           = wx;
        word.weight_y           = wy;
        word.dest_pixel         = dst;
        word.inside_req         = in_sprite;
        texel_words_q.push_back(word);
        words_planned++;
    endtask

    always @(posedge i_clk) begin : p_drive
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                blended_px_q.push_back(filter_and_blend(i_data));
                words_taken++;
                if (i_data.weight_x > WGT_ONE || i_data.weight_y > WGT_ONE) heavy_weights++;
                if (!i_data.inside_req) outside_words++;
            end
            if (i_start && o_busy) begin
                // The word has not been taken yet, so it stays on the port.
            end else if (gap_left > 0) begin
                gap_left--;
                i_start <= 1'b0;
            end else if (texel_words_q.size() > 0) begin
                i_data   <= texel_words_q.pop_front();
                i_start  <= 1'b1;
                gap_left = pick_gap();
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : p_check
        t_btob_out want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (blended_px_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: pixel %08h we %b",
                             o_data.out_pixel, o_data.write_enable);
            end else begin
                want = blended_px_q.pop_front();
                if (o_data.out_pixel !== want.out_pixel ||
                    o_data.write_enable !== want.write_enable) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d mismatch: pixel %08h we %b, expected %08h we %b",
                                 results_seen, o_data.out_pixel, o_data.write_enable,
                                 want.out_pixel, want.write_enable);
                end
            end
        end
    end

    always @(posedge i_clk) begin : p_watchdog
        if (!i_rst_n || (i_start && !o_busy) || o_valid)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, blended_px_q.size());
            $display("tb_bilinear_texel_over_blend_top: done, errors");
            $finish;
        end
    end

    initial begin
        // Extremes of every field.
        queue_word('0, '0, '0, '0, '0, '0, '0, 1'b0);
        queue_word('1, '1, '1, '1, 9'(WGT_ONE), 9'(WGT_ONE), '1, 1'b1);
        queue_word('1, '1, '1, '1, '1, '1, '0, 1'b1);
        // Corner selection by the weights.
        queue_word(32'h11223344, 32'h55667788, 32'h99AABBCC, 32'hDDEEFF00, '0, '0,
                   32'h80808080, 1'b1);
        queue_word(32'h11223344, 32'h55667788, 32'h99AABBCC, 32'hDDEEFF00, 9'(WGT_ONE), '0,
                   32'h80808080, 1'b1);
        queue_word(32'h11223344, 32'h55667788, 32'h99AABBCC, 32'hDDEEFF00, '0, 9'(WGT_ONE),
                   32'h80808080, 1'b1);
        queue_word(32'h11223344, 32'h55667788, 32'h99AABBCC, 32'hDDEEFF00, 9'(WGT_ONE),
                   9'(WGT_ONE), 32'h80808080, 1'b1);
        // Weights above one clamp to the right texel or the bottom row.
        queue_word(32'h10203040, 32'hF0E0D0C0, 32'h0A0B0C0D, 32'hA0B0C0D0, 9'(WGT_ONE + 1),
                   9'h1FF, 32'h7F7F7F7F, 1'b1);
        queue_word(32'h10203040, 32'hF0E0D0C0, 32'h0A0B0C0D, 32'hA0B0C0D0, 9'h1FF,
                   9'(WGT_ONE + 1), 32'h01020304, 1'b0);
        // Colour above alpha overflows the channel and must saturate.
        queue_word(32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 9'd77, 9'd200,
                   '1, 1'b1);
        queue_word(32'h40FF80FF, 32'h20FFFF00, 32'h00C0C0C0, 32'h10FFFFFF, 9'd128, 9'd128,
                   32'h00F0F0F0, 1'b1);
        // Opaque texels hide the destination; transparent black shows it through.
        queue_word(32'hFF102030, 32'hFF405060, 32'hFF708090, 32'hFFA0B0C0, 9'd1, 9'd255,
                   32'h5A5A5A5A, 1'b1);
        queue_word('0, '0, '0, '0, 9'd128, 9'd64, 32'hA5C3E1F7, 1'b1);
        // Outside pixels still produce a full colour with the write enable low.
        queue_word(32'h80402010, 32'hFF00FF00, 32'h00FF00FF, 32'h7F7F7F7F, 9'd255, 9'd1,
                   32'h12345678, 1'b0);
        queue_word(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 9'h155, 9'h0AA,
                   32'h55AA55AA, 1'b0);

        for (int n = 0; n < RAND_WORDS; n++) begin
            queue_word(rand_texel(), rand_texel(), rand_texel(), rand_texel(), rand_weight(),
                       rand_weight(), $urandom(), ($urandom_range(0, 4) != 0));
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken < words_planned || blended_px_q.size() > 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 5) @(posedge i_clk);

        $display("Sent %0d words (%0d outside, %0d with a weight above one), checked %0d results.",
                 words_taken, outside_words, heavy_weights, results_seen);
        $display("Saturated colour channels predicted: %0d; mismatches: %0d.",
                 clipped_chans, errors);
        if (errors == 0)
            $display("tb_bilinear_texel_over_blend_top: done, clean");
        else
            $display("tb_bilinear_texel_over_blend_top: done, errors");
        $finish;
    end

endmodule
